>>> rtl/core/leg_pkg.sv
// shared types, codes and control program of the light effect generator
`timescale 1ns / 1ps

package leg_pkg;

    localparam int LEVEL_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int PC_W = 3;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [1:0] {
        MODE_FADE    = 2'd0,
        MODE_GLOW    = 2'd1,
        MODE_FLICKER = 2'd2,
        MODE_STROBE  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_LEVEL_UPPER = 3'd1,
        CFG_LEVEL_LOWER = 3'd2,
        CFG_RAMP_STEPS  = 3'd3,
        CFG_UPPER_DWELL = 3'd4,
        CFG_LOWER_DWELL = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_NO_ITEM  = 3'd1,
        COND_NO_RAMP  = 3'd2,
        COND_DIV_MORE = 3'd3,
        COND_OUT_BUSY = 3'd4
    } cond_t;

    localparam pc_t STEP_FETCH    = 3'd0;
    localparam pc_t STEP_DECODE   = 3'd1;
    localparam pc_t STEP_DIV_LOAD = 3'd2;
    localparam pc_t STEP_DIV_STEP = 3'd3;
    localparam pc_t STEP_EXEC     = 3'd4;
    localparam pc_t STEP_EMIT     = 3'd5;

    typedef struct packed {
        logic  take_item;
        logic  div_load;
        logic  div_step;
        logic  exec;
        logic  emit;
        cond_t cond;
        pc_t   target;
        logic  last;
    } ctrl_word_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // control program: jump to target when cond holds, else back to fetch after the last step, else next step
    function automatic ctrl_word_t ctrl_rom(input pc_t pc);
        ctrl_word_t w;
        w = '0;
        w.cond = COND_NEVER;
        w.target = STEP_FETCH;
        case (pc)
            STEP_FETCH:
            begin
                w.take_item = 1'b1;
                w.cond = COND_NO_ITEM;
                w.target = STEP_FETCH;
            end
            STEP_DECODE:
            begin
                w.cond = COND_NO_RAMP;
                w.target = STEP_EXEC;
            end
            STEP_DIV_LOAD:
            begin
                w.div_load = 1'b1;
            end
            STEP_DIV_STEP:
            begin
                w.div_step = 1'b1;
                w.cond = COND_DIV_MORE;
                w.target = STEP_DIV_STEP;
            end
            STEP_EXEC:
            begin
                w.exec = 1'b1;
            end
            STEP_EMIT:
            begin
                w.emit = 1'b1;
                w.cond = COND_OUT_BUSY;
                w.target = STEP_EMIT;
                w.last = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/leg_in_if.sv
// input request channel of the light effect generator
`timescale 1ns / 1ps

interface leg_in_if
    import leg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] random_byte;

    modport source (output valid, output action, output start_level, output random_byte,
                    input ready);
    modport sink (input valid, input action, input start_level, input random_byte,
                  output ready);
endinterface

>>> rtl/core/leg_out_if.sv
// result request channel of the light effect generator
`timescale 1ns / 1ps

interface leg_out_if
    import leg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] light_level;
    logic               running;

    modport source (output valid, output light_level, output running, input ready);
    modport sink (input valid, input light_level, input running, output ready);
endinterface

>>> rtl/core/leg_divider.sv
// restoring divider, one quotient bit per cycle while step is asserted, 8-bit divisor
`timescale 1ns / 1ps

module leg_divider
    import leg_pkg::*;
#(
    parameter int NUM_W = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctrl_t          ctrl,
    input  logic [NUM_W-1:0]   numerator,
    input  logic [LEVEL_W-1:0] divisor,
    output logic [NUM_W-1:0]   quotient,
    output logic               more
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [LEVEL_W:0]   rem_reg;
    logic [LEVEL_W:0]   rem_next;
    logic [NUM_W-1:0]   work_reg;
    logic [NUM_W-1:0]   work_next;
    logic [LEVEL_W-1:0] den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [LEVEL_W:0]   shifted;
    logic               fits;

    always_comb
    begin
        shifted = {rem_reg[LEVEL_W-1:0], work_reg[NUM_W-1]};
        fits = (shifted >= {1'b0, den_reg});
        rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;
        work_next = {work_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= CNT_W'(NUM_W - 1);
        end
        else if (ctrl.step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= '0;
            work_reg <= numerator;
            den_reg <= divisor;
        end
        else if (ctrl.step)
        begin
            rem_reg <= rem_next;
            work_reg <= work_next;
        end
    end

    assign quotient = work_reg;
    assign more = (cnt_reg != '0);

endmodule

>>> rtl/core/light_effect_generator.sv
// top level: one light channel with fade, glow, flicker and strobe effects
`timescale 1ns / 1ps

// One light channel whose level (0 to 255, held with FRAC_BITS fraction bits) follows the
// effect chosen in the mode register. Every request on items gives exactly one request on results.
// A tick, and a start of flicker or strobe, goes through fetch, decode, execute and emit
// to the result register. A start of fade or glow also passes through the divider
// load and divider steps after decode, where the restoring divider forms the per-tick step
// one quotient bit per cycle. One request is in work at a time; the next is taken while the
// previous result still waits in the output register, and emit waits only if that register
// is still full. Configuration registers are written through cfg_write_en, cfg_index and
// cfg_data; the user writes them only while the channel is idle, which the block does not enforce.
module light_effect_generator
    import leg_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data,
    leg_in_if.sink               items,
    leg_out_if.source            results
);

    localparam int LW = LEVEL_W + FRAC_BITS;
    localparam int SW = LW + 1;
    localparam logic [LW-1:0] MAX_FIX = {{LEVEL_W{1'b1}}, {FRAC_BITS{1'b0}}};

    // configuration
    mode_t              mode_reg;
    logic [LEVEL_W-1:0] upper_reg;
    logic [LEVEL_W-1:0] lower_reg;
    logic [LEVEL_W-1:0] steps_reg;
    logic [LEVEL_W-1:0] up_dwell_reg;
    logic [LEVEL_W-1:0] lo_dwell_reg;

    // sequencer and latched request
    pc_t                pc_reg;
    pc_t                pc_next;
    ctrl_word_t         word;
    logic               taken;
    logic               act_reg;
    logic [LEVEL_W-1:0] start_reg;
    logic [LEVEL_W-1:0] rnd_reg;

    // effect state
    logic [LW-1:0]      level_reg;
    logic [LW-1:0]      level_next;
    logic [SW-1:0]      step_reg;
    logic [SW-1:0]      step_next;
    logic               up_reg;
    logic               up_next;
    logic [LEVEL_W-1:0] wait_reg;
    logic [LEVEL_W-1:0] wait_next;
    logic               active_reg;
    logic               active_next;

    // result register
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic               out_running_reg;
    logic               out_busy;

    // divider
    div_ctrl_t          div_ctrl;
    logic [LEVEL_W:0]   diff;
    logic [LEVEL_W-1:0] diff_mag;
    logic [LW-1:0]      numerator;
    logic [LEVEL_W-1:0] divisor;
    logic [LW-1:0]      quotient;
    logic               div_more;

    assign word = ctrl_rom(pc_reg);
    assign out_busy = out_valid_reg && !results.ready;

    assign diff = {1'b0, upper_reg} - {1'b0, start_reg};
    assign diff_mag = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];
    assign numerator = {diff_mag, {FRAC_BITS{1'b0}}};
    assign divisor = (steps_reg == '0) ? LEVEL_W'(1) : steps_reg;
    assign div_ctrl = '{load: word.div_load, step: word.div_step};

    leg_divider #(
        .NUM_W (LW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .numerator (numerator),
        .divisor   (divisor),
        .quotient  (quotient),
        .more      (div_more)
    );

    always_comb
    begin
        case (word.cond)
            COND_NO_ITEM:  taken = !items.valid;
            COND_NO_RAMP:  taken = !(act_reg && (mode_reg == MODE_FADE || mode_reg == MODE_GLOW));
            COND_DIV_MORE: taken = div_more;
            COND_OUT_BUSY: taken = out_busy;
            default:       taken = 1'b0;
        endcase
        if (taken)
        begin
            pc_next = word.target;
        end
        else if (word.last)
        begin
            pc_next = STEP_FETCH;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    assign items.ready = word.take_item;

    // effect update for one request
    always_comb
    begin
        logic [LW-1:0]  up_fix;
        logic [LW-1:0]  lo_fix;
        logic [SW-1:0]  q_ext;
        logic [SW:0]    sum;
        logic [LW-1:0]  clamped;

        up_fix = {upper_reg, {FRAC_BITS{1'b0}}};
        lo_fix = {lower_reg, {FRAC_BITS{1'b0}}};
        q_ext = {1'b0, quotient};
        sum = {2'b00, level_reg} + {step_reg[SW-1], step_reg};
        if (sum[SW])
        begin
            clamped = '0;
        end
        else if (sum[SW-1:0] > {1'b0, MAX_FIX})
        begin
            clamped = MAX_FIX;
        end
        else
        begin
            clamped = sum[LW-1:0];
        end

        level_next = level_reg;
        step_next = step_reg;
        up_next = up_reg;
        wait_next = wait_reg;
        active_next = active_reg;

        if (act_reg)
        begin
            active_next = 1'b1;
            case (mode_reg)
                MODE_FADE, MODE_GLOW:
                begin
                    level_next = {start_reg, {FRAC_BITS{1'b0}}};
                    wait_next = '0;
                    step_next = diff[LEVEL_W] ? SW'(-q_ext) : q_ext;
                    up_next = (start_reg <= upper_reg);
                end
                MODE_FLICKER:
                begin
                    level_next = up_fix;
                    wait_next = {1'b0, rnd_reg[6], 5'b00000, 1'b1};
                end
                default:
                begin
                    level_next = up_fix;
                    wait_next = up_dwell_reg;
                end
            endcase
        end
        else if (active_reg)
        begin
            if (wait_reg != '0)
            begin
                wait_next = wait_reg - 1'b1;
            end
            else
            begin
                case (mode_reg)
                    MODE_FADE:
                    begin
                        level_next = clamped;
                        if (up_reg ? (clamped >= up_fix) : (clamped <= up_fix))
                        begin
                            level_next = up_fix;
                            active_next = 1'b0;
                        end
                    end
                    MODE_GLOW:
                    begin
                        level_next = clamped;
                        if (up_reg)
                        begin
                            if (clamped >= up_fix)
                            begin
                                level_next = up_fix;
                                step_next = -step_reg;
                                up_next = 1'b0;
                            end
                        end
                        else if (clamped <= lo_fix)
                        begin
                            level_next = lo_fix;
                            step_next = -step_reg;
                            up_next = 1'b1;
                        end
                    end
                    MODE_FLICKER:
                    begin
                        if (level_reg == up_fix)
                        begin
                            level_next = lo_fix;
                            wait_next = {5'b00000, rnd_reg[2:0]} + 1'b1;
                        end
                        else
                        begin
                            level_next = up_fix;
                            wait_next = {3'b000, rnd_reg[4:0]} + 1'b1;
                        end
                    end
                    default:
                    begin
                        if (level_reg == up_fix)
                        begin
                            level_next = lo_fix;
                            wait_next = lo_dwell_reg;
                        end
                        else
                        begin
                            level_next = up_fix;
                            wait_next = up_dwell_reg;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FADE;
            upper_reg <= 8'd255;
            lower_reg <= 8'd0;
            steps_reg <= 8'd1;
            up_dwell_reg <= 8'd1;
            lo_dwell_reg <= 8'd1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg <= mode_t'(cfg_data[1:0]);
                CFG_LEVEL_UPPER: upper_reg <= cfg_data;
                CFG_LEVEL_LOWER: lower_reg <= cfg_data;
                CFG_RAMP_STEPS:  steps_reg <= cfg_data;
                CFG_UPPER_DWELL: up_dwell_reg <= cfg_data;
                CFG_LOWER_DWELL: lo_dwell_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_FETCH;
            level_reg <= '0;
            step_reg <= '0;
            up_reg <= 1'b1;
            wait_reg <= '0;
            active_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (word.exec)
            begin
                level_reg <= level_next;
                step_reg <= step_next;
                up_reg <= up_next;
                wait_reg <= wait_next;
                active_reg <= active_next;
            end
            if (word.emit && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (word.take_item && items.valid)
        begin
            act_reg <= items.action;
            start_reg <= items.start_level;
            rnd_reg <= items.random_byte;
        end
        if (word.emit && !out_busy)
        begin
            out_level_reg <= level_reg[LW-1:FRAC_BITS];
            out_running_reg <= active_reg;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.light_level = out_level_reg;
    assign results.running = out_running_reg;

endmodule

>>> rtl/core/leg_checker.sv
// port checks for the light effect generator, bound to the top level
`timescale 1ns / 1ps

module leg_checker
    import leg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [LEVEL_W-1:0] out_level,
    input logic               out_running
);

    // result held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_level) && $stable(out_running))
        else $error("stalled result changed");

    // one request in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    // decode and execute come before any result of a new request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result appeared too soon after a request");

endmodule

bind light_effect_generator leg_checker u_leg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_level   (results.light_level),
    .out_running (results.running)
);
